[hdl/dhm_pkg.sv]
// Shared types and constants for the depth-to-heat-map converter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package dhm_pkg;

    localparam int DEPTH_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int RAMP_COLORS = 5;

    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RESET = 16'd200;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 16'd10000;
    localparam logic [CHAN_W-1:0]  CHAN_FULL       = 8'hFF;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_MIN_DEPTH = 1'b0,
        REG_MAX_DEPTH = 1'b1
    } t_reg_idx;

    // one bit per channel, {red, green, blue}
    typedef logic [2:0] t_rgb_bits;

    // blue, green, yellow, red, black
    localparam t_rgb_bits RAMP [RAMP_COLORS] = '{3'b001, 3'b010, 3'b110, 3'b100, 3'b000};

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic               depth_invalid;
    } t_pixel_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel_out;

    typedef struct packed {
        logic [DEPTH_W-1:0] min_depth_mm;
        logic [DEPTH_W-1:0] max_depth_mm;
        logic [DEPTH_W-1:0] span_mm;
    } t_cfg;

    typedef struct packed {
        logic               black;
        logic [DEPTH_W-1:0] depth_mm;
    } t_front_item;

endpackage

`default_nettype wire

[hdl/dhm_cfg.sv]
// APB register file: minimum and maximum depth, plus a registered span.
// Depends on dhm_pkg.
`default_nettype none

module dhm_cfg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output dhm_pkg::t_cfg             o_cfg
);

    logic [dhm_pkg::DEPTH_W-1:0] r_min;
    logic [dhm_pkg::DEPTH_W-1:0] r_max;
    logic [dhm_pkg::DEPTH_W-1:0] r_span;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= dhm_pkg::MIN_DEPTH_RESET;
            r_max <= dhm_pkg::MAX_DEPTH_RESET;
        end else if (w_wr) begin
            if (paddr[2] == dhm_pkg::REG_MIN_DEPTH) begin
                r_min <= pwdata[dhm_pkg::DEPTH_W-1:0];
            end else begin
                r_max <= pwdata[dhm_pkg::DEPTH_W-1:0];
            end
        end
    end

    // span is only meaningful when max > min; the front stage blacks out the rest
    always_ff @(posedge i_clk) begin
        r_span <= r_max - r_min;
    end

    always_comb begin
        if (paddr[2] == dhm_pkg::REG_MIN_DEPTH) begin
            prdata = {16'b0, r_min};
        end else begin
            prdata = {16'b0, r_max};
        end
    end

    assign o_cfg = '{min_depth_mm: r_min, max_depth_mm: r_max, span_mm: r_span};

endmodule

`default_nettype wire

[hdl/dhm_front.sv]
// Input stage: range checks that decide a black pixel before division.
// Depends on dhm_pkg.
`default_nettype none

module dhm_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire dhm_pkg::t_pixel_in   i_pixel,
    input  wire dhm_pkg::t_cfg        i_cfg,
    output logic                      o_vld,
    output dhm_pkg::t_front_item      o_item
);

    logic                 r_vld;
    dhm_pkg::t_front_item r_item;
    logic                 w_below;
    logic                 w_above;
    logic                 w_empty;
    logic                 w_over;
    logic [16:0]          w_sum;

    assign w_below = i_pixel.depth_mm < i_cfg.min_depth_mm;
    assign w_above = i_pixel.depth_mm > i_cfg.max_depth_mm;
    assign w_empty = i_cfg.max_depth_mm <= i_cfg.min_depth_mm;
    // scaled reaches the end of the ramp exactly when depth >= max - min
    assign w_sum   = {1'b0, i_pixel.depth_mm} + {1'b0, i_cfg.min_depth_mm};
    assign w_over  = w_sum >= {1'b0, i_cfg.max_depth_mm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.black    <= i_pixel.depth_invalid | w_below | w_above | w_empty | w_over;
            r_item.depth_mm <= i_pixel.depth_mm;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

[hdl/dhm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, depth * 2^(F+2) / span.
// Depends on dhm_pkg.
`default_nettype none

module dhm_div #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire dhm_pkg::t_front_item          i_item,
    input  wire logic [dhm_pkg::DEPTH_W-1:0]   i_span,
    output logic                               o_vld,
    output logic                               o_black,
    output logic [FRAC_BITS+1:0]               o_quo
);

    localparam int QW = FRAC_BITS + 2;

    logic                        r_vld   [QW];
    logic                        r_black [QW];
    logic [dhm_pkg::DEPTH_W-1:0] r_rem   [QW];
    logic [QW-1:0]               r_quo   [QW];

    logic                        w_src_black [QW];
    logic [dhm_pkg::DEPTH_W-1:0] w_src_rem   [QW];
    logic [QW-1:0]               w_src_quo   [QW];
    logic [dhm_pkg::DEPTH_W:0]   w_shift     [QW];
    logic [dhm_pkg::DEPTH_W:0]   w_diff      [QW];
    logic [QW-1:0]               w_ge;
    logic [dhm_pkg::DEPTH_W-1:0] n_rem       [QW];
    logic [QW-1:0]               n_quo       [QW];

    // the remainder stays below span, so the shifted value fits 17 bits
    always_comb begin
        w_src_black[0] = i_item.black;
        w_src_rem[0]   = i_item.depth_mm;
        w_src_quo[0]   = '0;
        for (int k = 1; k < QW; k++) begin
            w_src_black[k] = r_black[k-1];
            w_src_rem[k]   = r_rem[k-1];
            w_src_quo[k]   = r_quo[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_shift[k] = {w_src_rem[k], 1'b0};
            w_diff[k]  = w_shift[k] - {1'b0, i_span};
            w_ge[k]    = w_shift[k] >= {1'b0, i_span};
            n_rem[k]   = w_ge[k] ? w_diff[k][dhm_pkg::DEPTH_W-1:0]
                                 : w_shift[k][dhm_pkg::DEPTH_W-1:0];
            n_quo[k]   = {w_src_quo[k][QW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < QW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_black[k] <= w_src_black[k];
                r_rem[k]   <= n_rem[k];
                r_quo[k]   <= n_quo[k];
            end
        end
    end

    assign o_vld   = r_vld[QW-1];
    assign o_black = r_black[QW-1];
    assign o_quo   = r_quo[QW-1];

    // stage k has produced only k+1 quotient bits
    for (genvar k = 0; k < QW - 1; k++) begin : g_quo_chk
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] |-> (r_quo[k] >> (k + 1)) == '0)
            else $error("dhm_div: quotient bits above stage position");
    end

endmodule

`default_nettype wire

[hdl/dhm_blend.sv]
// Color stage: picks the ramp segment and blends each channel, output register.
// Depends on dhm_pkg.
`default_nettype none

module dhm_blend #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic                  i_black,
    input  wire logic [FRAC_BITS+1:0]  i_quo,
    output logic                       o_vld,
    output dhm_pkg::t_pixel_out        o_pixel
);

    localparam int QW = FRAC_BITS + 2;

    logic [1:0]               w_seg;
    logic [FRAC_BITS-1:0]     w_frac;
    logic [FRAC_BITS+7:0]     w_prod_up;
    logic [FRAC_BITS:0]       w_comp;
    logic [FRAC_BITS+8:0]     w_prod_dn;
    logic [dhm_pkg::CHAN_W-1:0] w_up;
    logic [dhm_pkg::CHAN_W-1:0] w_dn;
    logic [2:0]               w_idx_lo;
    logic [2:0]               w_idx_hi;
    dhm_pkg::t_rgb_bits       w_c1;
    dhm_pkg::t_rgb_bits       w_c2;
    dhm_pkg::t_pixel_out      n_pixel;
    logic                     r_vld;
    dhm_pkg::t_pixel_out      r_pixel;

    function automatic logic [dhm_pkg::CHAN_W-1:0] chan_level(
        input logic                       c1,
        input logic                       c2,
        input logic [dhm_pkg::CHAN_W-1:0] up,
        input logic [dhm_pkg::CHAN_W-1:0] dn
    );
        logic [dhm_pkg::CHAN_W-1:0] lvl;
        case ({c1, c2})
            2'b00:   lvl = '0;
            2'b01:   lvl = up;
            2'b10:   lvl = dn;
            default: lvl = dhm_pkg::CHAN_FULL;
        endcase
        return lvl;
    endfunction

    assign w_seg  = i_quo[QW-1:QW-2];
    assign w_frac = i_quo[FRAC_BITS-1:0];

    // x * 255 = (x << 8) - x
    assign w_prod_up = {w_frac, 8'b0} - {8'b0, w_frac};
    assign w_comp    = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, w_frac};
    assign w_prod_dn = {w_comp, 8'b0} - {8'b0, w_comp};
    assign w_up      = w_prod_up[FRAC_BITS+7:FRAC_BITS];
    assign w_dn      = w_prod_dn[FRAC_BITS+7:FRAC_BITS];

    assign w_idx_lo = {1'b0, w_seg};
    assign w_idx_hi = w_idx_lo + 3'd1;
    assign w_c1     = dhm_pkg::RAMP[w_idx_lo];
    assign w_c2     = dhm_pkg::RAMP[w_idx_hi];

    always_comb begin
        if (i_black) begin
            n_pixel = '0;
        end else begin
            n_pixel.red   = chan_level(w_c1[2], w_c2[2], w_up, w_dn);
            n_pixel.green = chan_level(w_c1[1], w_c2[1], w_up, w_dn);
            n_pixel.blue  = chan_level(w_c1[0], w_c2[0], w_up, w_dn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_vld   = r_vld;
    assign o_pixel = r_pixel;

    // no ramp segment has red and blue lit together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_pixel.red == '0 || r_pixel.blue == '0))
        else $error("dhm_blend: red and blue both nonzero");

endmodule

`default_nettype wire

[hdl/depth_to_heatmap_rgb_top.sv]
// Top level of the depth-to-heat-map converter: register file, range check,
// divider pipeline and color stage. Depends on dhm_pkg, dhm_cfg, dhm_front, dhm_div, dhm_blend.
`default_nettype none

// Usage
//   Input channel: i_valid / o_stall carry one depth item (millimetres plus an
//   invalid flag). Output channel: o_valid / i_stall carry one RGB item.
//   Every accepted item gives exactly one result item, in order.
//   Throughput: one item per clock while the output is not held. The item
//   passes FRACTION_BITS + 4 register stages: the range-check stage, loaded at
//   the accepting edge, the restoring divider, which resolves one quotient bit
//   per stage over FRACTION_BITS + 2 stages, and the color/output stage.
//   The whole pipeline advances together; it holds only when the output
//   register is full and the receiver stalls, and then o_stall rises in the
//   same cycle. Bubbles move on while the output is empty or taken.
//   Invalid pixels, depths outside [min, max], an empty or inverted span and
//   depths at or past the span give black.
//   APB registers: min_depth_mm at 0x0, max_depth_mm at 0x4; pready is always
//   high. Write them only with the pipeline empty.
//   Reset (synchronous, active low) drops every item in flight and restores
//   min 200 mm / max 10000 mm. No clearing pass is needed.
module depth_to_heatmap_rgb_top #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire dhm_pkg::t_pixel_in   i_pixel,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output dhm_pkg::t_pixel_out       o_pixel,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    dhm_pkg::t_cfg          w_cfg;
    dhm_pkg::t_front_item   w_front_item;
    logic                   w_front_vld;
    logic                   w_div_vld;
    logic                   w_div_black;
    logic [FRACTION_BITS+1:0] w_div_quo;
    logic                   w_adv;

    // advance everything unless a finished item is waiting on the receiver
    assign w_adv   = ~o_valid | ~i_stall;
    assign o_stall = ~w_adv;

    dhm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // range checks against the live registers
    dhm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_valid),
        .i_pixel (i_pixel),
        .i_cfg   (w_cfg),
        .o_vld   (w_front_vld),
        .o_item  (w_front_item)
    );

    // the registered span is settled by the time an item reaches the divider
    dhm_div #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_front_vld),
        .i_item  (w_front_item),
        .i_span  (w_cfg.span_mm),
        .o_vld   (w_div_vld),
        .o_black (w_div_black),
        .o_quo   (w_div_quo)
    );

    dhm_blend #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_div_vld),
        .i_black (w_div_black),
        .i_quo   (w_div_quo),
        .o_vld   (o_valid),
        .o_pixel (o_pixel)
    );

    // upstream is held only behind a waiting output item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("top: input stalled without a blocked output item");

    // an accepted item is in the range-check stage in the cycle after its acceptance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_valid && !o_stall) |-> w_front_vld)
        else $error("top: accepted item lost at the input stage");

endmodule

`default_nettype wire
